// ----- hdl/range_min_max_query_assert.svh -----
// Assertion macros shared by the range query engine modules.
`ifndef RANGE_MIN_MAX_QUERY_ASSERT_SVH
`define RANGE_MIN_MAX_QUERY_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RMQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("range query check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RMQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("range query check failed");

`endif

// ----- hdl/rmq_pkg.sv -----
// Types, constants and control structures of the range query engine.
`default_nettype none

package rmq_pkg;

    localparam int DEPTH  = 1024;
    localparam int LEVELS = 11;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 10;
    localparam int LEN_W  = 11;

    localparam int POS_W  = ($clog2(DEPTH) > IDX_W) ? $clog2(DEPTH) : IDX_W;
    localparam int CNT_W  = POS_W + 1;
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int LVL_AW = $clog2(LEVELS);
    localparam int ADDR_W = LVL_AW + POS_W;
    localparam int TABLE_DEPTH = LEVELS * (2 ** POS_W);
    localparam int SPAN_W = LEVELS + CNT_W;
    localparam int K_W    = $clog2(CNT_W);

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BUILD = 2'd1,
        ACT_QUERY = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD_RD,
        ST_BUILD_WR,
        ST_QUERY
    } t_state;

    typedef struct packed {
        t_action                  action;
        logic [IDX_W-1:0]         position;
        logic signed [DATA_W-1:0] element_value;
        logic [IDX_W-1:0]         left_index;
        logic [IDX_W-1:0]         right_index;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] range_max;
        logic signed [DATA_W-1:0] range_min;
        logic                     bad_range;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic build_rd;
        logic build_wr;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic build_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/range_min_max_query.sv -----
// Top level of the sparse-table range maximum and minimum query engine.
// Items enter on the input channel (i_in_valid, o_in_stall) and results leave on the
// output channel (o_out_valid, i_out_stall). An item is taken when valid is high and
// stall is low. The array length register is written through i_cfg_valid and
// o_cfg_ready; the user must write it only while the engine is idle, as the block
// itself does not enforce it; ready is always high. A load item writes level zero of
// both tables and gives no result. A query item issues its table reads at acceptance;
// the registered read data then goes into the output register. The dual read port
// of the table memory reads both halves at once. A build item gives no result; for
// each entry it reads the two halves in ST_BUILD_RD and writes in ST_BUILD_WR.
// The engine holds the input channel stalled while a build or query is in work.
// If the receiver stalls, the result stays in the output register and a following
// query waits until that register frees.
// Reset sets the array length to one and empties the output register. Table contents
// are undefined until loaded and built, so no clearing pass runs after reset.
`default_nettype none

module range_min_max_query (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire rmq_pkg::t_in_item         i_in_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output rmq_pkg::t_out_item             o_out_item,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [rmq_pkg::LEN_W-1:0] i_cfg_data
);

    import rmq_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    rmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_item.action),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rmq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ----- hdl/rmq_ram.sv -----
// Generic single-write, dual-read memory with registered read data.
`default_nettype none

module rmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rmq_ctrl.sv -----
// Controller state machine that sequences loads, table builds and queries.
`default_nettype none
`include "range_min_max_query_assert.svh"

module rmq_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire rmq_pkg::t_action    i_action,
    input  wire rmq_pkg::t_dp_status i_status,
    output rmq_pkg::t_ctrl_cmd       o_cmd,
    output logic                     o_in_stall
);

    import rmq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_BUILD) begin
                        n_state = ST_BUILD_RD;
                    end else if (i_action == ACT_QUERY) begin
                        n_state = ST_QUERY;
                    end
                end
            end
            ST_BUILD_RD: begin
                n_state = i_status.build_done ? ST_IDLE : ST_BUILD_WR;
            end
            ST_BUILD_WR: begin
                n_state = ST_BUILD_RD;
            end
            ST_QUERY: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_BUILD_RD: begin
                o_cmd.build_rd = !i_status.build_done;
            end
            ST_BUILD_WR: begin
                o_cmd.build_wr = 1'b1;
            end
            ST_QUERY: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    `RMQ_ASSERT_NXT(a_build_start, r_state == ST_IDLE && i_in_valid && i_action == ACT_BUILD, r_state == ST_BUILD_RD)
    `RMQ_ASSERT_IMP(a_write_after_read, r_state == ST_BUILD_WR, $past(r_state) == ST_BUILD_RD)
    `RMQ_ASSERT_NXT(a_query_waits, r_state == ST_QUERY && !i_status.out_free, r_state == ST_QUERY)

endmodule

`default_nettype wire

// ----- hdl/rmq_datapath.sv -----
// Datapath with the max and min tables, build counters, query addressing and result register.
`default_nettype none
`include "range_min_max_query_assert.svh"

module rmq_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rmq_pkg::t_ctrl_cmd        i_cmd,
    input  wire rmq_pkg::t_in_item         i_in_item,
    input  wire logic                      i_cfg_valid,
    input  wire logic [rmq_pkg::LEN_W-1:0] i_cfg_data,
    input  wire logic                      i_out_stall,
    output rmq_pkg::t_dp_status            o_status,
    output logic                           o_out_valid,
    output rmq_pkg::t_out_item             o_out_item
);

    import rmq_pkg::*;

    logic [LEN_W-1:0]  r_array_length;
    logic [LVL_W-1:0]  r_lvl;
    logic [POS_W-1:0]  r_idx;
    logic              r_bad;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [CNT_W-1:0]  eff_n;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] half;
    logic [LVL_W-1:0]  lvl_prev;
    logic              level_last;

    logic [POS_W-1:0]  q_l;
    logic [POS_W-1:0]  q_r;
    logic [CNT_W-1:0]  q_len;
    logic [K_W-1:0]    k_raw;
    logic [LVL_AW-1:0] q_k;
    logic [CNT_W-1:0]  q_p_full;
    logic              q_bad;
    logic [POS_W-1:0]  ld_pos;
    logic              ld_ok;

    logic              acc_load;
    logic              acc_build;
    logic              acc_query;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [DATA_W-1:0] wdata_max;
    logic [DATA_W-1:0] wdata_min;
    logic [DATA_W-1:0] max_a;
    logic [DATA_W-1:0] max_b;
    logic [DATA_W-1:0] min_a;
    logic [DATA_W-1:0] min_b;
    logic [DATA_W-1:0] sel_max;
    logic [DATA_W-1:0] sel_min;

    assign acc_load  = i_cmd.accept && (i_in_item.action == ACT_LOAD);
    assign acc_build = i_cmd.accept && (i_in_item.action == ACT_BUILD);
    assign acc_query = i_cmd.accept && (i_in_item.action == ACT_QUERY);

    assign eff_n = (CNT_W'(r_array_length) > CNT_W'(DEPTH)) ?
                   CNT_W'(DEPTH) : CNT_W'(r_array_length);

    assign span       = SPAN_W'(1) << r_lvl;
    assign half       = span >> 1;
    assign lvl_prev   = r_lvl - LVL_W'(1);
    assign level_last = (SPAN_W'(r_idx) + SPAN_W'(1) + span) > SPAN_W'(eff_n);

    assign o_status.build_done = (r_lvl >= LVL_W'(LEVELS)) || (span > SPAN_W'(eff_n));
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign ld_pos = POS_W'(i_in_item.position);
    assign ld_ok  = CNT_W'(ld_pos) < CNT_W'(DEPTH);

    assign q_l   = POS_W'(i_in_item.left_index);
    assign q_r   = POS_W'(i_in_item.right_index);
    assign q_len = CNT_W'(q_r) - CNT_W'(q_l) + CNT_W'(1);
    assign q_bad = (q_l > q_r) || (CNT_W'(q_r) >= eff_n);

    always_comb begin
        k_raw = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (q_len[b]) begin
                k_raw = K_W'(b);
            end
        end
    end

    assign q_k      = (int'(k_raw) > LEVELS - 1) ? LVL_AW'(LEVELS - 1) : LVL_AW'(k_raw);
    assign q_p_full = CNT_W'(q_r) + CNT_W'(1) - (CNT_W'(1) << q_k);

    assign sel_max = ($signed(max_a) > $signed(max_b)) ? max_a : max_b;
    assign sel_min = ($signed(min_a) < $signed(min_b)) ? min_a : min_b;

    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = '0;
        wdata_max   = '0;
        wdata_min   = '0;
        ram_re      = 1'b0;
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        if (acc_load && ld_ok) begin
            ram_we    = 1'b1;
            ram_waddr = {LVL_AW'(0), ld_pos};
            wdata_max = i_in_item.element_value;
            wdata_min = i_in_item.element_value;
        end else if (i_cmd.build_wr) begin
            ram_we    = 1'b1;
            ram_waddr = {r_lvl[LVL_AW-1:0], r_idx};
            wdata_max = sel_max;
            wdata_min = sel_min;
        end
        if (acc_query) begin
            ram_re      = 1'b1;
            ram_raddr_a = {q_k, q_l};
            ram_raddr_b = {q_k, q_p_full[POS_W-1:0]};
        end else if (i_cmd.build_rd) begin
            ram_re      = 1'b1;
            ram_raddr_a = {lvl_prev[LVL_AW-1:0], r_idx};
            ram_raddr_b = {lvl_prev[LVL_AW-1:0], r_idx + half[POS_W-1:0]};
        end
    end

    rmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_max_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (wdata_max),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (max_a),
        .o_rdata_b (max_b)
    );

    rmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_min_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (wdata_min),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (min_a),
        .o_rdata_b (min_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_length <= LEN_W'(1);
            r_lvl          <= '0;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_array_length <= i_cfg_data;
            end
            if (acc_build) begin
                r_lvl <= LVL_W'(1);
                r_idx <= '0;
            end else if (i_cmd.build_wr) begin
                if (level_last) begin
                    r_lvl <= r_lvl + LVL_W'(1);
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + POS_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_query) begin
            r_bad <= q_bad;
        end
        if (i_cmd.emit) begin
            if (r_bad) begin
                r_out.range_max <= '0;
                r_out.range_min <= '0;
                r_out.bad_range <= 1'b1;
            end else begin
                r_out.range_max <= sel_max;
                r_out.range_min <= sel_min;
                r_out.bad_range <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `RMQ_ASSERT_IMP(a_out_from_emit, $rose(r_out_valid), $past(i_cmd.emit))
    `RMQ_ASSERT_IMP(a_build_level, i_cmd.build_rd, r_lvl >= LVL_W'(1) && r_lvl < LVL_W'(LEVELS))

endmodule

`default_nettype wire

// ----- bench/range_min_max_query_checker.sv -----
`timescale 1ns / 1ps
// Checker for the range query engine: predicts each query result and compares it.
module range_min_max_query_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire rmq_pkg::t_in_item         i_in_item,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire rmq_pkg::t_out_item        i_out_item,
    input  wire logic                      i_cfg_valid,
    input  wire logic                      i_cfg_ready,
    input  wire logic [rmq_pkg::LEN_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import rmq_pkg::*;

    logic signed [DATA_W-1:0] max_level [LEVELS][DEPTH];
    logic signed [DATA_W-1:0] min_level [LEVELS][DEPTH];
    logic [LEN_W-1:0]         length_reg = 1;
    t_out_item                answers_due [$];
    int                       fail_total = 0;

    function automatic int unsigned used_length();
        return (length_reg > DEPTH) ? DEPTH : length_reg;
    endfunction

    task automatic build_levels();
        int unsigned n;
        int unsigned span;
        int unsigned half;
        int unsigned j;
        int unsigned i;
        n = used_length();
        for (j = 1; j < LEVELS; j++) begin
            span = 1 << j;
            half = span >> 1;
            if (span > n) break;
            for (i = 0; i + span <= n; i++) begin
                max_level[j][i] = (max_level[j-1][i] > max_level[j-1][i+half]) ?
                                  max_level[j-1][i] : max_level[j-1][i+half];
                min_level[j][i] = (min_level[j-1][i] < min_level[j-1][i+half]) ?
                                  min_level[j-1][i] : min_level[j-1][i+half];
            end
        end
    endtask

    function automatic t_out_item answer_query(logic [IDX_W-1:0] l, logic [IDX_W-1:0] r);
        t_out_item   res;
        int unsigned n;
        int unsigned span_len;
        int unsigned k;
        int unsigned p;
        res = '0;
        n = used_length();
        if (l > r || r >= n) begin
            res.bad_range = 1'b1;
            return res;
        end
        span_len = r - l + 1;
        k = 0;
        while (k + 1 < 32 && (span_len >> (k + 1)) != 0) k++;
        if (k >= LEVELS) k = LEVELS - 1;
        p = r + 1 - (1 << k);
        res.range_max = (max_level[k][l] > max_level[k][p]) ? max_level[k][l] : max_level[k][p];
        res.range_min = (min_level[k][l] < min_level[k][p]) ? min_level[k][l] : min_level[k][p];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item expected;
        if (!i_rst_n) begin
            length_reg = 1;
            answers_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) length_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                case (i_in_item.action)
                    ACT_LOAD: begin
                        max_level[0][i_in_item.position] = i_in_item.element_value;
                        min_level[0][i_in_item.position] = i_in_item.element_value;
                    end
                    ACT_BUILD: build_levels();
                    ACT_QUERY: begin
                        answers_due.push_back(answer_query(i_in_item.left_index,
                                                           i_in_item.right_index));
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $error("result item arrived with no query outstanding");
                    fail_total++;
                end else begin
                    expected = answers_due.pop_front();
                    if (i_out_item.range_max !== expected.range_max) begin
                        $error("range_max expected %0d got %0d",
                               expected.range_max, i_out_item.range_max);
                        fail_total++;
                    end
                    if (i_out_item.range_min !== expected.range_min) begin
                        $error("range_min expected %0d got %0d",
                               expected.range_min, i_out_item.range_min);
                        fail_total++;
                    end
                    if (i_out_item.bad_range !== expected.bad_range) begin
                        $error("bad_range expected %0d got %0d",
                               expected.bad_range, i_out_item.bad_range);
                        fail_total++;
                    end
                end
            end
        end
        o_pending <= answers_due.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Top of the range query bench: clock, reset, item stimulus, watchdog and verdict.
module tb;
    import rmq_pkg::*;

    typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HALF, FLOW_HEAVY} t_stall_mode;

    localparam t_action ACT_SPARE  = t_action'(2'd3);
    localparam int      IDLE_LIMIT = 50000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_in_item         in_item = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data = '0;
    int               fail_count;
    int               results_owed;

    bit               loaded_pos [DEPTH];
    int unsigned      live_length = 1;
    int unsigned      built_span = 0;
    int               burst_left = 0;
    bit               steady_flow = 1'b0;
    t_stall_mode      stall_mode = FLOW_FREE;
    int               stall_run = 0;
    int               idle_cycles = 0;

    always #5 clk = ~clk;

    range_min_max_query DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    range_min_max_query_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (results_owed)
    );

    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_run  <= $urandom_range(16, 160);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            FLOW_FREE:  out_stall <= 1'b0;
            FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
            default:    out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_fields(t_action act);
        t_in_item item;
        item = {$urandom, $urandom};
        item.action = act;
        return item;
    endfunction

    function automatic t_in_item load_item(int unsigned pos, logic signed [DATA_W-1:0] value);
        t_in_item item;
        item = random_fields(ACT_LOAD);
        item.position = IDX_W'(pos);
        item.element_value = value;
        return item;
    endfunction

    function automatic t_in_item query_item(int unsigned l, int unsigned r);
        t_in_item item;
        item = random_fields(ACT_QUERY);
        item.left_index = IDX_W'(l);
        item.right_index = IDX_W'(r);
        return item;
    endfunction

    // Picks a range that the block must reject, so the result holds zeros and bad_range.
    function automatic t_in_item bad_query();
        logic [IDX_W-1:0] l;
        logic [IDX_W-1:0] r;
        do begin
            l = IDX_W'($urandom);
            r = IDX_W'($urandom);
        end while (l <= r && r < live_length);
        return query_item(l, r);
    endfunction

    // Valid ranges stay inside the span covered by some earlier build.
    function automatic t_in_item good_query(bit single);
        int unsigned top;
        int unsigned l;
        int unsigned r;
        top = (live_length < built_span) ? live_length : built_span;
        if (top == 0) return bad_query();
        l = $urandom_range(0, top - 1);
        if (single) begin
            r = l;
        end else if ($urandom_range(0, 4) == 0) begin
            l = $urandom_range(0, (top > 4) ? 3 : 0);
            r = top - 1;
        end else if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(l, (l + 8 < top) ? l + 8 : top - 1);
        end else begin
            r = $urandom_range(l, top - 1);
        end
        return query_item(l, r);
    endfunction

    task automatic send_item(input t_in_item item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = steady_flow ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        case (item.action)
            ACT_LOAD:  loaded_pos[item.position] = 1'b1;
            ACT_BUILD: if (live_length > built_span) built_span = live_length;
            default: ;
        endcase
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        live_length = (value > DEPTH) ? DEPTH : value;
    endtask

    // Every position under the new length is loaded before the build, and
    // each phase ends on a query so the engine is idle once it answers.
    task automatic run_phase(input logic [LEN_W-1:0] len_value, input int count);
        int          pick;
        int unsigned p;
        settle();
        write_length(len_value);
        steady_flow = ($urandom_range(0, 3) == 0);
        for (p = 0; p < live_length; p++)
            if (!loaded_pos[p]) send_item(load_item(p, pick_value()));
        send_item(random_fields(ACT_BUILD));
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_item(good_query(1'b0));
            else if (pick < 70)
                send_item(bad_query());
            else if (pick < 88)
                send_item(load_item($urandom_range(0, DEPTH - 1), pick_value()));
            else if (pick < 93 && live_length <= 300)
                send_item(random_fields(ACT_BUILD));
            else if (pick < 96)
                send_item(random_fields(ACT_SPARE));
            else
                send_item(good_query(1'b1));
        end
        send_item(bad_query());
    endtask

    initial begin
        int               phase;
        logic [LEN_W-1:0] span_choice;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item('1);
        send_item(query_item(1, 0));
        send_item(query_item(0, 1));
        send_item(load_item(0, 32'h8000_0000));
        send_item(query_item(0, 0));
        settle();
        write_length(4);
        send_item(load_item(1, 32'h7FFF_FFFF));
        send_item(load_item(2, 0));
        send_item(load_item(3, 32'hFFFF_FFFF));
        send_item(load_item(DEPTH - 1, 32'h5A5A_A5A5));
        send_item(random_fields(ACT_BUILD));
        send_item(query_item(0, 3));
        send_item(query_item(1, 2));
        send_item(query_item(2, 3));
        send_item(query_item(3, 3));
        send_item(query_item(3, 0));
        send_item(query_item(0, 4));
        send_item(query_item(DEPTH - 1, DEPTH - 1));
        // A load after the build leaves the upper levels stale.
        send_item(load_item(1, 5));
        send_item(query_item(1, 1));
        send_item(query_item(0, 3));
        settle();
        write_length(0);
        send_item(query_item(0, 0));
        send_item(random_fields(ACT_BUILD));
        send_item(query_item(0, 0));

        for (phase = 0; phase < 16; phase++) begin
            case (phase)
                0:       span_choice = 1;
                1:       span_choice = 2;
                4:       span_choice = LEN_W'(DEPTH);
                9:       span_choice = '1;
                12:      span_choice = 0;
                default: span_choice = LEN_W'(($urandom_range(0, 3) == 0) ?
                                       $urandom_range(65, 300) : $urandom_range(3, 64));
            endcase
            run_phase(span_choice, 55);
        end

        settle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
